// ===== rtl/gre_pkg.sv =====
// Shared constants and types for the GCD reduction block.
// No dependencies; imported by gre_gcd_unit and the top level.
package gre_pkg;

  localparam int GRE_COEFF_WIDTH = 32;  // default magnitude datapath width
  localparam int GRE_DATA_WIDTH  = 32;  // tdata width on both stream ports

  // Status of the shared GCD unit, seen by the sequencer
  typedef struct packed {
    logic busy;  // reduction in progress
    logic done;  // result valid this cycle
  } gre_status_t;

endpackage

// ===== rtl/gre_gcd_unit.sv =====
// Iterative binary GCD unit: one shift or one compare-subtract per cycle.
// Depends on gre_pkg for the status struct.
module gre_gcd_unit
  import gre_pkg::*;
#(
  parameter int COEFF_WIDTH = GRE_COEFF_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COEFF_WIDTH-1:0] op_a,
  input  logic [COEFF_WIDTH-1:0] op_b,
  output gre_status_t            status,
  output logic [COEFF_WIDTH-1:0] result
);

  localparam int KW = $clog2(COEFF_WIDTH);

  logic [COEFF_WIDTH-1:0] a_r, a_nxt;
  logic [COEFF_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic                   busy_r, busy_nxt;

  logic                   a_ge_b;
  logic [COEFF_WIDTH-1:0] big, sml, diff;
  logic                   done;

  // one shared compare and subtract
  assign a_ge_b = (a_r >= b_r);
  assign big    = a_ge_b ? a_r : b_r;
  assign sml    = a_ge_b ? b_r : a_r;
  assign diff   = big - sml;

  assign done   = busy_r && ((a_r == '0) || (b_r == '0));
  // restore the common power of two
  assign result = ((a_r == '0) ? b_r : a_r) << k_r;

  assign status.busy = busy_r;
  assign status.done = done;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (done) begin
        busy_nxt = 1'b0;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_ge_b) begin
        a_nxt = diff >> 1;  // odd minus odd is even
      end else begin
        b_nxt = diff >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

endmodule

// ===== rtl/gcd_reduction_with_exclusion_top.sv =====
// GCD of the included magnitudes of a streamed vector, one coefficient per transfer.
// Per item: accept step, binary GCD unit (skipped for excluded items), finish step.
// in_tready is low while an item is being folded; the result register holds one result.
// out_tvalid is set from the last item's finish step, once the result register is free.
// Reset (rst_n, synchronous, active low) clears the running divisor and all control.
module gcd_reduction_with_exclusion_top
  import gre_pkg::*;
#(
  parameter int COEFF_WIDTH = GRE_COEFF_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic signed [GRE_DATA_WIDTH-1:0] in_tdata,   // [31:0] coefficient
  input  logic                             in_tuser,   // [0] excluded
  input  logic                             in_tlast,   // last element of the vector
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [GRE_DATA_WIDTH-1:0]        out_tdata   // [31:0] divisor
);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // waiting for an input transfer
    S_RUN  = 3'b010,  // GCD unit folding the element in
    S_FIN  = 3'b100   // emit result on last, then back to idle
  } state_t;

  state_t                   state_r, state_nxt;
  logic [COEFF_WIDTH-1:0]   div_r, div_nxt;      // running divisor
  logic                     any_r, any_nxt;      // some element included
  logic                     last_r, last_nxt;    // item being worked on is last
  logic                     ovalid_r, ovalid_nxt;
  logic [GRE_DATA_WIDTH-1:0] odata_r, odata_nxt;

  logic                     in_xfer;
  logic [COEFF_WIDTH-1:0]   raw;
  logic [COEFF_WIDTH-1:0]   mag;
  logic                     gcd_start;
  gre_status_t              gcd_status;
  logic [COEFF_WIDTH-1:0]   gcd_result;
  logic                     out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  // result register can take a new value this cycle
  assign out_free   = !ovalid_r || out_tready;

  // magnitude of the coefficient read at COEFF_WIDTH bits; most negative gives 2^(W-1)
  assign raw = COEFF_WIDTH'(in_tdata);
  assign mag = raw[COEFF_WIDTH-1] ? (~raw + 1'b1) : raw;

  assign gcd_start = in_xfer && !in_tuser;

  gre_gcd_unit #(
    .COEFF_WIDTH(COEFF_WIDTH)
  ) u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .op_a   (div_r),
    .op_b   (mag),
    .status (gcd_status),
    .result (gcd_result)
  );

  always_comb begin
    state_nxt  = state_r;
    div_nxt    = div_r;
    any_nxt    = any_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_tlast;
          if (!in_tuser) begin
            any_nxt   = 1'b1;
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RUN: begin
        if (gcd_status.done) begin
          div_nxt   = gcd_result;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          // empty inclusion set reports 1
          odata_nxt  = any_r ? GRE_DATA_WIDTH'(div_r) : GRE_DATA_WIDTH'(1);
          ovalid_nxt = 1'b1;
          div_nxt    = '0;
          any_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_r    <= '0;
      any_r    <= 1'b0;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_r    <= div_nxt;
      any_r    <= any_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
    end
    odata_r <= odata_nxt;
  end

`ifndef SYNTHESIS
  // no new item while the GCD unit is reducing
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_status.busy |-> !in_tready)
    else $error("input accepted while GCD unit busy");

  // an excluded element never starts the GCD unit
  a_excluded_skips_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser) |=> (!gcd_status.busy && state_r == S_FIN))
    else $error("excluded element entered the GCD unit");

  // a result only comes out of the finish step of a last item
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == S_FIN && last_r))
    else $error("result produced without a last item");

  // the unit finishes only while the sequencer waits for it
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_status.done |-> (state_r == S_RUN))
    else $error("GCD result outside run state");
`endif

endmodule
